// ----- hdl/ddq_pkg.sv -----
package ddq_pkg;

    // Fixed field widths
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;

    // Default sizing handed to the top level
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Work queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = 1;
    localparam int FQ_CNT_W = 2;

    // Command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // One classified word: a submit carries its deadline, a tick the new time
    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] payload;
        logic [TIME_W-1:0] stamp;
    } t_work;

endpackage

// ----- hdl/ddq_front.sv -----
module ddq_front
    import ddq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_command,
    input  logic [DATA_W-1:0]  i_payload,
    input  logic [DELAY_W-1:0] i_delay_ms,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output t_work              o_work
);

    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W-1:0] w_next_time;

    // Stall while the work queue is full
    assign o_stall     = i_full;
    assign o_push      = i_valid && !i_full;
    assign w_next_time = r_time + TIME_W'(1);

    // Stamp submits with their deadline and ticks with the new time
    always_comb begin
        o_work.cmd     = i_command;
        o_work.payload = i_payload;
        if (i_command == CMD_TICK) begin
            o_work.stamp = w_next_time;
        end else begin
            o_work.stamp = r_time + TIME_W'(i_delay_ms);
        end
    end

    // Advance the time counter on each accepted tick
    always_comb begin
        n_time = r_time;
        if (o_push && i_command == CMD_TICK) begin
            n_time = w_next_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            r_time <= n_time;
        end
    end

endmodule

// ----- hdl/ddq_fifo.sv -----
module ddq_fifo
    import ddq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_work
);

    t_work               r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wp;
    logic [FQ_PTR_W-1:0] r_rp;
    logic [FQ_CNT_W-1:0] r_cnt;
    logic [FQ_PTR_W-1:0] n_wp;
    logic [FQ_PTR_W-1:0] n_rp;
    logic [FQ_CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rp];

    // Move pointers and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Write the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule

// ----- hdl/ddq_back.sv -----
module ddq_back
    import ddq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wvalid,
    input  t_work             i_work,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_released_payload,
    output logic              o_dropped,
    output logic              o_last
);

    localparam int SW = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

    // Sorted store: slot 0 is the earliest deadline, valid bits form a thermometer
    logic [TIME_W-1:0] r_dl  [QUEUE_DEPTH];
    logic [SW-1:0]     r_pay [QUEUE_DEPTH];
    logic [TIME_W-1:0] n_dl  [QUEUE_DEPTH];
    logic [SW-1:0]     n_pay [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_vld;
    logic [QUEUE_DEPTH-1:0] n_vld;
    logic [QUEUE_DEPTH-1:0] w_stay;

    logic              r_ovld;
    logic [DATA_W-1:0] r_opay;
    logic              r_odrop;
    logic              r_olast;
    logic              n_ovld;
    logic [DATA_W-1:0] n_opay;
    logic              n_odrop;
    logic              n_olast;

    logic              w_load;
    logic              w_due0;
    logic              w_due1;
    logic              w_full;
    logic [DATA_W-1:0] w_head;

    // a lies strictly before b by wrapping difference
    function automatic logic before_t(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

    assign w_load = !r_ovld || !i_stall;
    assign w_full = r_vld[QUEUE_DEPTH-1];
    assign w_due0 = r_vld[0] && before_t(r_dl[0], i_work.stamp);
    assign w_due1 = r_vld[1] && before_t(r_dl[1], i_work.stamp);

    // Zero-extend the head payload
    always_comb begin
        w_head         = '0;
        w_head[SW-1:0] = r_pay[0];
    end

    // Entries that keep their slot on insert: deadline not after the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_stay[i] = r_vld[i] && !before_t(i_work.stamp, r_dl[i]);
        end
    end

    // Execute the word at the head of the work queue
    always_comb begin
        n_dl    = r_dl;
        n_pay   = r_pay;
        n_vld   = r_vld;
        n_ovld  = r_ovld;
        n_opay  = r_opay;
        n_odrop = r_odrop;
        n_olast = r_olast;
        o_pop   = 1'b0;
        if (r_ovld && !i_stall) begin
            n_ovld = 1'b0;
        end
        if (i_wvalid) begin
            unique case (i_work.cmd)
                CMD_SUBMIT: begin
                    if (w_full) begin
                        // drop and flag
                        if (w_load) begin
                            n_ovld  = 1'b1;
                            n_opay  = '0;
                            n_odrop = 1'b1;
                            n_olast = 1'b1;
                            o_pop   = 1'b1;
                        end
                    end else begin
                        // insert after equal deadlines, shift the rest up
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                            if (!w_stay[i]) begin
                                if (i == 0 || w_stay[(i == 0) ? 0 : i - 1]) begin
                                    n_dl[i]  = i_work.stamp;
                                    n_pay[i] = i_work.payload[SW-1:0];
                                end else begin
                                    n_dl[i]  = r_dl[(i == 0) ? 0 : i - 1];
                                    n_pay[i] = r_pay[(i == 0) ? 0 : i - 1];
                                end
                            end
                        end
                        n_vld = {r_vld[QUEUE_DEPTH-2:0], 1'b1};
                        o_pop = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (!w_due0) begin
                        o_pop = 1'b1;
                    end else if (w_load) begin
                        // release the head, shift the store down
                        n_ovld  = 1'b1;
                        n_opay  = w_head;
                        n_odrop = 1'b0;
                        n_olast = !w_due1;
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            n_dl[i]  = r_dl[i+1];
                            n_pay[i] = r_pay[i+1];
                        end
                        n_vld = {1'b0, r_vld[QUEUE_DEPTH-1:1]};
                        o_pop = !w_due1;
                    end
                end
                default: begin
                    o_pop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_ovld <= n_ovld;
        end
    end

    // Hold store contents and the output word
    always_ff @(posedge i_clk) begin
        r_dl    <= n_dl;
        r_pay   <= n_pay;
        r_opay  <= n_opay;
        r_odrop <= n_odrop;
        r_olast <= n_olast;
    end

    assign o_valid            = r_ovld;
    assign o_released_payload = r_opay;
    assign o_dropped          = r_odrop;
    assign o_last             = r_olast;

endmodule

// ----- hdl/deadline_delay_queue_top.sv -----
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_command, i_payload, i_delay_ms
// result    out        o_valid / i_stall   o_released_payload, o_dropped, o_last
//
// The front stamps each word with its deadline or new time as it is accepted;
// a two-word queue feeds the back. A submit is a parallel compare-and-shift
// over the store. A tick with nothing due is simply popped; otherwise it
// releases the due entries one by one, paced by the single output register,
// and is popped with the last. Reset is synchronous and clears time, store
// and queue. Output stall holds releases and drops while the front keeps
// accepting until the queue fills.
module deadline_delay_queue_top
    import ddq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [DATA_W-1:0]  i_payload,
    input  logic [DELAY_W-1:0] i_delay_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DATA_W-1:0]  o_released_payload,
    output logic               o_dropped,
    output logic               o_last
);

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_wvalid;
    t_work w_in_work;
    t_work w_out_work;

    ddq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .i_payload  (i_payload),
        .i_delay_ms (i_delay_ms),
        .i_full     (w_full),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_work     (w_in_work)
    );

    ddq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_in_work),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_wvalid),
        .o_work  (w_out_work)
    );

    ddq_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_wvalid           (w_wvalid),
        .i_work             (w_out_work),
        .o_pop              (w_pop),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_released_payload (o_released_payload),
        .o_dropped          (o_dropped),
        .o_last             (o_last)
    );

endmodule
